// ===== rtl/core/range_add_range_sum_fenwick_macros.svh =====
// Assertion macros for the range add / range sum block.
// Needs signals named clock and reset in the including module.
`ifndef RANGE_ADD_RANGE_SUM_FENWICK_MACROS_SVH
`define RANGE_ADD_RANGE_SUM_FENWICK_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define RARF_ASSERT_IMP(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (prop)) \
      else $error(msg);

// Next-cycle implication, checked outside reset.
`define RARF_ASSERT_NEXT(label, cond, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (prop)) \
      else $error(msg);

`endif

// ===== rtl/core/rarf_pkg.sv =====
// Shared constants for the range add / range sum block.
// No dependencies.
`timescale 1ns / 1ps

package rarf_pkg;

   localparam int MAX_ELEMENTS = 1024;
   localparam int DEPTH        = MAX_ELEMENTS + 1;
   localparam int ADDR_W       = $clog2(DEPTH);
   localparam int PTR_W        = ADDR_W + 1;
   localparam int CNT_W        = 11;
   localparam int IDX_W        = 11;
   localparam int KIND_W       = 3;
   localparam int VAL_W        = 32;
   localparam int SUM_W        = 64;

   localparam logic [KIND_W-1:0] KIND_LOAD      = 3'd0;
   localparam logic [KIND_W-1:0] KIND_RANGE_ADD = 3'd1;
   localparam logic [KIND_W-1:0] KIND_ADD_FIRST = 3'd2;
   localparam logic [KIND_W-1:0] KIND_SUB_FIRST = 3'd3;
   localparam logic [KIND_W-1:0] KIND_RANGE_SUM = 3'd4;
   localparam logic [KIND_W-1:0] KIND_READ_FIRST = 3'd5;

endpackage

// ===== rtl/core/range_add_range_sum_fenwick.sv =====
// Range add / range sum array held as two Fenwick trees in block memories.
// Depends on rarf_pkg and range_add_range_sum_fenwick_macros.svh.
`timescale 1ns / 1ps

// Usage
// Requests arrive on req_* (valid/ready); a beat is taken only when the
// block is idle, and one request is worked at a time. Loads must fill all
// elements in order before any other kind is honoured. Range sums and
// read-first give one beat on rsp_* (valid/ready); other kinds give none.
// Writing csr_wdata with csr_we sets the element count and restarts loading.
// Each tree entry visited takes a read step, then an accumulate or
// modify-write step, on the memory port shared by the two trees, plus a
// multiply step per path and a subtract step per prefix for sums. A
// finished result waits in the output register; a new request is taken
// while it waits, and the block only holds in its final step if a second
// result is ready before the first is taken.
// Reset clears control state and sets the count to 1024; tree contents are
// undefined until loaded, so no clearing pass runs.
module range_add_range_sum_fenwick (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic [rarf_pkg::KIND_W-1:0]      req_kind,
   input  logic [rarf_pkg::IDX_W-1:0]       req_index_low,
   input  logic [rarf_pkg::IDX_W-1:0]       req_index_high,
   input  logic signed [rarf_pkg::VAL_W-1:0] req_value,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [rarf_pkg::SUM_W-1:0] rsp_result,
   output logic                             rsp_range_error,
   input  logic                             csr_we,
   input  logic [rarf_pkg::CNT_W-1:0]       csr_wdata
);

`include "range_add_range_sum_fenwick_macros.svh"

   localparam int PW = rarf_pkg::PTR_W;
   localparam int SW = rarf_pkg::SUM_W;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_READ = 7'b0000010,
      S_MOD  = 7'b0000100,
      S_MUL  = 7'b0001000,
      S_LDW  = 7'b0010000,
      S_SUB  = 7'b0100000,
      S_FIN  = 7'b1000000
   } state_type;

   state_type                    state_ff, state_in;
   logic [rarf_pkg::KIND_W-1:0]  kind_ff, kind_in;
   logic                         phase_ff, phase_in;
   logic [PW-1:0]                ptr_ff, ptr_in;
   logic [PW-1:0]                stop_ff, stop_in;
   logic [PW-1:0]                base_ff, base_in;
   logic [PW-1:0]                next_ff, next_in;
   logic [SW-1:0]                amt_ff, amt_in;
   logic [SW-1:0]                accd_ff, accd_in;
   logic [SW-1:0]                accw_ff, accw_in;
   logic [SW-1:0]                prod_ff, prod_in;
   logic [SW-1:0]                sum_ff, sum_in;
   logic                         err_ff, err_in;
   logic [rarf_pkg::VAL_W-1:0]   value_ff, value_in;
   logic [rarf_pkg::VAL_W-1:0]   prev_ff, prev_in;
   logic [rarf_pkg::CNT_W-1:0]   loaded_ff, loaded_in;
   logic [rarf_pkg::CNT_W-1:0]   ecount_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   logic [SW-1:0]                rsp_result_ff, rsp_result_in;
   logic                         rsp_err_ff, rsp_err_in;

   // Tree memories and their registered read data.
   logic [SW-1:0] dmem [rarf_pkg::DEPTH];
   logic [SW-1:0] wmem [rarf_pkg::DEPTH];
   logic [SW-1:0] drd_ff, wrd_ff;
   logic                        mem_we;
   logic [rarf_pkg::ADDR_W-1:0] mem_addr;
   logic [SW-1:0]               dwd, wwd;

   logic [PW-1:0] n_act, lo_w, hi_w, loaded_w, up_ptr, down_ptr;
   logic          ready_w, range_ok, fin_fire, add_out;
   logic [SW-1:0] part;

   // Active element count and request checks.
   always_comb begin
      n_act    = (PW'(ecount_ff) < PW'(rarf_pkg::MAX_ELEMENTS)) ? PW'(ecount_ff)
                                                                : PW'(rarf_pkg::MAX_ELEMENTS);
      lo_w     = PW'(req_index_low);
      hi_w     = PW'(req_index_high);
      loaded_w = PW'(loaded_ff);
      ready_w  = loaded_w >= n_act;
      range_ok = (lo_w != '0) && (lo_w <= hi_w) && (hi_w <= n_act);
      up_ptr   = ptr_ff + (ptr_ff & (~ptr_ff + PW'(1)));
      down_ptr = ptr_ff & (ptr_ff - PW'(1));
      add_out  = (state_ff == S_MUL) ? (ptr_ff > n_act) : (up_ptr > n_act);
      part     = prod_ff - accw_ff;
      fin_fire = (state_ff == S_FIN) && (!rsp_valid_ff || rsp_ready);
   end

   assign req_ready = (state_ff == S_IDLE);

   // Memory port: reads in the read step, writes in modify or load-write.
   always_comb begin
      mem_we   = 1'b0;
      mem_addr = ptr_ff[rarf_pkg::ADDR_W-1:0];
      dwd      = drd_ff + amt_ff;
      wwd      = wrd_ff + prod_ff;
      if (state_ff == S_LDW) begin
         mem_we   = 1'b1;
         mem_addr = base_ff[rarf_pkg::ADDR_W-1:0];
         dwd      = amt_ff + accd_ff;
         wwd      = prod_ff + accw_ff;
      end else if (state_ff == S_MOD && (kind_ff == rarf_pkg::KIND_RANGE_ADD ||
                   kind_ff == rarf_pkg::KIND_ADD_FIRST ||
                   kind_ff == rarf_pkg::KIND_SUB_FIRST)) begin
         mem_we = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         dmem[mem_addr] <= dwd;
         wmem[mem_addr] <= wwd;
      end
      drd_ff <= dmem[mem_addr];
      wrd_ff <= wmem[mem_addr];
   end

   // Sequencer next-state logic.
   always_comb begin
      state_in  = state_ff;
      kind_in   = kind_ff;
      phase_in  = phase_ff;
      ptr_in    = ptr_ff;
      stop_in   = stop_ff;
      base_in   = base_ff;
      next_in   = next_ff;
      amt_in    = amt_ff;
      accd_in   = accd_ff;
      accw_in   = accw_ff;
      prod_in   = prod_ff;
      sum_in    = sum_ff;
      err_in    = err_ff;
      value_in  = value_ff;
      prev_in   = prev_ff;
      loaded_in = loaded_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               kind_in  = req_kind;
               value_in = req_value;
               phase_in = 1'b0;
               accd_in  = '0;
               accw_in  = '0;
               stop_in  = '0;
               case (req_kind)
                  rarf_pkg::KIND_LOAD: begin
                     if (!ready_w) begin
                        base_in  = loaded_w + PW'(1);
                        ptr_in   = loaded_w;
                        stop_in  = loaded_w & (loaded_w + PW'(1));
                        amt_in   = SW'(signed'(req_value)) - SW'(signed'(prev_ff));
                        state_in = (loaded_w != (loaded_w & (loaded_w + PW'(1)))) ?
                                   S_READ : S_MUL;
                     end
                  end
                  rarf_pkg::KIND_RANGE_ADD: begin
                     if (ready_w && range_ok) begin
                        ptr_in   = lo_w;
                        base_in  = lo_w;
                        next_in  = hi_w + PW'(1);
                        amt_in   = SW'(signed'(req_value));
                        state_in = S_MUL;
                     end
                  end
                  rarf_pkg::KIND_ADD_FIRST, rarf_pkg::KIND_SUB_FIRST: begin
                     if (ready_w && n_act != '0) begin
                        ptr_in   = PW'(1);
                        base_in  = PW'(1);
                        next_in  = PW'(2);
                        amt_in   = (req_kind == rarf_pkg::KIND_ADD_FIRST) ?
                                   SW'(signed'(req_value)) : -SW'(signed'(req_value));
                        state_in = S_MUL;
                     end
                  end
                  rarf_pkg::KIND_RANGE_SUM: begin
                     if (ready_w && range_ok) begin
                        ptr_in   = hi_w;
                        base_in  = hi_w + PW'(1);
                        next_in  = lo_w - PW'(1);
                        err_in   = 1'b0;
                        state_in = S_READ;
                     end else begin
                        sum_in   = '0;
                        err_in   = 1'b1;
                        state_in = S_FIN;
                     end
                  end
                  rarf_pkg::KIND_READ_FIRST: begin
                     if (ready_w && n_act != '0) begin
                        ptr_in   = PW'(1);
                        err_in   = 1'b0;
                        state_in = S_READ;
                     end else begin
                        sum_in   = '0;
                        err_in   = 1'b1;
                        state_in = S_FIN;
                     end
                  end
                  default: begin
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_READ: begin
            state_in = S_MOD;
         end
         S_MOD: begin
            if (kind_ff == rarf_pkg::KIND_RANGE_ADD || kind_ff == rarf_pkg::KIND_ADD_FIRST ||
                kind_ff == rarf_pkg::KIND_SUB_FIRST) begin
               // Ascending walk: the write-back happens this cycle.
               ptr_in = up_ptr;
               if (!add_out) begin
                  state_in = S_READ;
               end else if (!phase_ff) begin
                  phase_in = 1'b1;
                  ptr_in   = next_ff;
                  base_in  = next_ff;
                  amt_in   = -amt_ff;
                  state_in = S_MUL;
               end else begin
                  state_in = S_IDLE;
               end
            end else begin
               // Descending walk: accumulate both trees.
               accd_in = accd_ff + drd_ff;
               accw_in = accw_ff + wrd_ff;
               ptr_in  = down_ptr;
               if (kind_ff == rarf_pkg::KIND_READ_FIRST) begin
                  sum_in   = accd_ff + drd_ff;
                  state_in = S_FIN;
               end else if (down_ptr == stop_ff) begin
                  state_in = S_MUL;
               end else begin
                  state_in = S_READ;
               end
            end
         end
         S_MUL: begin
            prod_in = ((kind_ff == rarf_pkg::KIND_RANGE_SUM) ? accd_ff : amt_ff) *
                      SW'(base_ff);
            if (kind_ff == rarf_pkg::KIND_LOAD) begin
               state_in = S_LDW;
            end else if (kind_ff == rarf_pkg::KIND_RANGE_SUM) begin
               state_in = S_SUB;
            end else if (!add_out) begin
               state_in = S_READ;
            end else if (!phase_ff) begin
               phase_in = 1'b1;
               ptr_in   = next_ff;
               base_in  = next_ff;
               amt_in   = -amt_ff;
               state_in = S_MUL;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_LDW: begin
            loaded_in = base_ff[rarf_pkg::CNT_W-1:0];
            prev_in   = value_ff;
            state_in  = S_IDLE;
         end
         S_SUB: begin
            if (!phase_ff) begin
               sum_in   = part;
               phase_in = 1'b1;
               ptr_in   = next_ff;
               base_in  = next_ff + PW'(1);
               accd_in  = '0;
               accw_in  = '0;
               state_in = (next_ff != '0) ? S_READ : S_MUL;
            end else begin
               sum_in   = sum_ff - part;
               state_in = S_FIN;
            end
         end
         S_FIN: begin
            if (fin_fire) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Output register: loaded from the final step, cleared when the beat goes.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_result_in = rsp_result_ff;
      rsp_err_in    = rsp_err_ff;
      if (fin_fire) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = sum_ff;
         rsp_err_in    = err_ff;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         loaded_ff    <= '0;
         prev_ff      <= '0;
         ecount_ff    <= rarf_pkg::CNT_W'(1024);
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            ecount_ff <= csr_wdata;
            loaded_ff <= '0;
            prev_ff   <= '0;
         end else begin
            loaded_ff <= loaded_in;
            prev_ff   <= prev_in;
         end
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      kind_ff       <= kind_in;
      phase_ff      <= phase_in;
      ptr_ff        <= ptr_in;
      stop_ff       <= stop_in;
      base_ff       <= base_in;
      next_ff       <= next_in;
      amt_ff        <= amt_in;
      accd_ff       <= accd_in;
      accw_ff       <= accw_in;
      prod_ff       <= prod_in;
      sum_ff        <= sum_in;
      err_ff        <= err_in;
      value_ff      <= value_in;
      rsp_result_ff <= rsp_result_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_result      = rsp_result_ff;
   assign rsp_range_error = rsp_err_ff;

   // Checks on the sequencer.
   `RARF_ASSERT_IMP(a_write_in_range, mem_we, (PW'(mem_addr) <= n_act) && (mem_addr != '0), "tree write outside active elements")
   `RARF_ASSERT_IMP(a_load_only_unready, state_ff == S_LDW, loaded_w < n_act, "load write after loading completed")
   `RARF_ASSERT_NEXT(a_fin_takes_beat, fin_fire, rsp_valid_ff && (rsp_result_ff == $past(sum_ff)), "final result not registered")

endmodule
